### rtl/core/bbs_pkg.sv
package bbs_pkg;

    localparam int CFG_WIDTH = 24;
    localparam int IDX_WIDTH = 2;
    localparam int PAT_WIDTH = 3;
    localparam int PHASE_WIDTH = 3;
    localparam int EXT_WIDTH = 32;

    localparam logic [IDX_WIDTH-1:0] CFG_SHORT_BEEP = 2'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_LONG_BEEP  = 2'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_GAP        = 2'd2;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [PAT_WIDTH-1:0] PAT_OFF    = 3'd0;
    localparam logic [PAT_WIDTH-1:0] PAT_SHORT  = 3'd1;
    localparam logic [PAT_WIDTH-1:0] PAT_LONG   = 3'd2;
    localparam logic [PAT_WIDTH-1:0] PAT_TWICE  = 3'd3;
    localparam logic [PAT_WIDTH-1:0] PAT_THRICE = 3'd4;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_beep_ticks;
        logic [CFG_WIDTH-1:0] long_beep_ticks;
        logic [CFG_WIDTH-1:0] gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PAT_WIDTH-1:0]   active_pattern;
        logic [PHASE_WIDTH-1:0] phase_count;
        logic                   pwm_enable;
    } seq_state_t;

    typedef struct packed {
        logic buzzer_on;
        logic busy_res;
        logic bad_pattern;
    } result_t;

endpackage

### rtl/core/bbs_step.sv
module bbs_step #(
    parameter int TICK_WIDTH = 24
) (
    input  bbs_pkg::seq_state_t                   state_i,
    input  logic [TICK_WIDTH-1:0]                 remaining_i,
    input  logic                                  func_i,
    input  logic [bbs_pkg::PAT_WIDTH-1:0]         pattern_i,
    input  bbs_pkg::cfg_t                         cfg_i,
    output bbs_pkg::seq_state_t                   state_o,
    output logic [TICK_WIDTH-1:0]                 remaining_o,
    output bbs_pkg::result_t                      result_o
);

    logic [bbs_pkg::EXT_WIDTH-1:0] short_ext;
    logic [bbs_pkg::EXT_WIDTH-1:0] long_ext;
    logic [bbs_pkg::EXT_WIDTH-1:0] gap_ext;
    logic [TICK_WIDTH-1:0]         short_load;
    logic [TICK_WIDTH-1:0]         long_load;
    logic [TICK_WIDTH-1:0]         gap_load;
    logic                          bad;

    // durations keep only the low TICK_WIDTH bits
    assign short_ext  = bbs_pkg::EXT_WIDTH'(cfg_i.short_beep_ticks);
    assign long_ext   = bbs_pkg::EXT_WIDTH'(cfg_i.long_beep_ticks);
    assign gap_ext    = bbs_pkg::EXT_WIDTH'(cfg_i.gap_ticks);
    assign short_load = short_ext[TICK_WIDTH-1:0];
    assign long_load  = long_ext[TICK_WIDTH-1:0];
    assign gap_load   = gap_ext[TICK_WIDTH-1:0];

    always_comb begin
        state_o     = state_i;
        remaining_o = remaining_i;
        bad         = 1'b0;
        if (func_i == bbs_pkg::FUNC_START) begin
            state_o     = '0;
            remaining_o = '0;
            unique case (pattern_i) inside
                bbs_pkg::PAT_OFF: begin
                end
                bbs_pkg::PAT_SHORT, bbs_pkg::PAT_TWICE, bbs_pkg::PAT_THRICE: begin
                    state_o.active_pattern = pattern_i;
                    state_o.pwm_enable     = 1'b1;
                    remaining_o            = short_load;
                end
                bbs_pkg::PAT_LONG: begin
                    state_o.active_pattern = pattern_i;
                    state_o.pwm_enable     = 1'b1;
                    remaining_o            = long_load;
                end
                default: begin
                    bad = 1'b1;
                end
            endcase
        end else if (state_i.active_pattern != bbs_pkg::PAT_OFF) begin
            if (remaining_i > TICK_WIDTH'(1)) begin
                remaining_o = remaining_i - TICK_WIDTH'(1);
            end else begin
                // expiry: alternate gap and short beep, odd phases are gaps
                state_o     = '0;
                remaining_o = '0;
                if ((state_i.active_pattern == bbs_pkg::PAT_TWICE &&
                     state_i.phase_count < 3'd2) ||
                    (state_i.active_pattern == bbs_pkg::PAT_THRICE &&
                     state_i.phase_count < 3'd4)) begin
                    state_o.active_pattern = state_i.active_pattern;
                    state_o.phase_count    = state_i.phase_count + 3'd1;
                    state_o.pwm_enable     = state_i.phase_count[0];
                    remaining_o            = state_i.phase_count[0] ? short_load : gap_load;
                end
            end
        end
    end

    assign result_o.buzzer_on   = state_o.pwm_enable;
    assign result_o.busy_res    = (state_o.active_pattern != bbs_pkg::PAT_OFF);
    assign result_o.bad_pattern = bad;

endmodule

### rtl/core/buzzer_beep_pattern_sequencer_unit.sv
// Channel  | Ports                                      | Direction
// s_       | s_valid s_ready s_func s_pattern           | in, one item per transfer
// m_       | m_valid m_ready m_buzzer_on m_busy_res ... | out, one result per item
// cfg_     | cfg_valid cfg_ready cfg_index cfg_wdata    | in, register writes
//
// One item per cycle while s_ready is high; its result is registered in the output
// register (or the skid entry on a stall). The sequencer state (pattern, phase, tick
// counter) updates on the same transfer, so the compare/decrement on the tick counter sets the loop.
// Reset: idle, buzzer off, durations 100/500/100; no clearing pass.
// Output stalls: a two-entry output (main + skid); s_ready is a register.
module buzzer_beep_pattern_sequencer_unit #(
    parameter int TICK_WIDTH = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [bbs_pkg::PAT_WIDTH-1:0]     s_pattern,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_buzzer_on,
    output logic                              m_busy_res,
    output logic                              m_bad_pattern,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bbs_pkg::IDX_WIDTH-1:0]     cfg_index,
    input  logic [bbs_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

    bbs_pkg::cfg_t         cfg_reg;
    bbs_pkg::seq_state_t   state_reg;
    bbs_pkg::seq_state_t   state_next;
    logic [TICK_WIDTH-1:0] remaining_reg;
    logic [TICK_WIDTH-1:0] remaining_next;
    bbs_pkg::result_t      result_next;
    bbs_pkg::result_t      out_reg;
    bbs_pkg::result_t      skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  in_xfer;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~skid_valid_reg;
    assign in_xfer   = s_valid & s_ready;
    assign out_free  = ~out_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_beep_ticks <= bbs_pkg::CFG_WIDTH'(100);
            cfg_reg.long_beep_ticks  <= bbs_pkg::CFG_WIDTH'(500);
            cfg_reg.gap_ticks        <= bbs_pkg::CFG_WIDTH'(100);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bbs_pkg::CFG_SHORT_BEEP: cfg_reg.short_beep_ticks <= cfg_wdata;
                bbs_pkg::CFG_LONG_BEEP:  cfg_reg.long_beep_ticks  <= cfg_wdata;
                bbs_pkg::CFG_GAP:        cfg_reg.gap_ticks        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bbs_step #(
        .TICK_WIDTH(TICK_WIDTH)
    ) u_step (
        .state_i     (state_reg),
        .remaining_i (remaining_reg),
        .func_i      (s_func),
        .pattern_i   (s_pattern),
        .cfg_i       (cfg_reg),
        .state_o     (state_next),
        .remaining_o (remaining_next),
        .result_o    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            remaining_reg <= '0;
        end else if (in_xfer) begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg  <= skid_valid_reg | in_xfer;
                skid_valid_reg <= 1'b0;
            end else if (in_xfer) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        end
        if (!out_free && in_xfer) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_buzzer_on   = out_reg.buzzer_on;
    assign m_busy_res    = out_reg.busy_res;
    assign m_bad_pattern = out_reg.bad_pattern;

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.active_pattern == bbs_pkg::PAT_OFF |->
            (state_reg.phase_count == '0 && !state_reg.pwm_enable && remaining_reg == '0))
        else $error("idle sequencer holds stale phase state");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_bad_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && result_next.bad_pattern |=> state_reg.active_pattern == bbs_pkg::PAT_OFF)
        else $error("unknown pattern left sequencer running");

    a_off_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.busy_res |-> !out_reg.buzzer_on)
        else $error("buzzer on while not busy");

endmodule
